### rtl/sysex_firmware_block_framer_macros.svh
// Assertion helpers for the SysEx block framer.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef SYSEX_FIRMWARE_BLOCK_FRAMER_MACROS_SVH
`define SYSEX_FIRMWARE_BLOCK_FRAMER_MACROS_SVH

// same-cycle implication
`define SFBF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFBF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfbf_pkg.sv
`timescale 1ns / 1ps
package sfbf_pkg;

    localparam int BLOCK_LEN = 64;
    localparam int POS_W     = $clog2(BLOCK_LEN);
    localparam int ADDR_W    = 28;
    localparam int QDEPTH    = 4;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int QC_W      = $clog2(QDEPTH + 1);
    localparam int IDX_W     = 4;

    localparam logic [1:0] OP_IMAGE  = 2'd0;
    localparam logic [1:0] OP_PAD    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [7:0] MFR_ID0   = 8'h00;
    localparam logic [7:0] MFR_ID1   = 8'h13;
    localparam logic [6:0] CMD_BLOCK = 7'h01;
    localparam logic [6:0] CMD_SUM   = 7'h03;
    localparam logic [6:0] LEN7      = 7'(BLOCK_LEN);
    localparam logic [6:0] DEV_ID_RST = 7'd56;

    typedef logic [6:0] t_sept;

    // one framing job handed from the front end to the byte sequencer
    typedef struct packed {
        logic              hdr;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        grp_len;
        t_sept             hb;
        t_sept [6:0]       grp;
        logic              close;
        t_sept             cks;
        logic              fin;
        logic [15:0]       cnt;
        logic [15:0]       sum;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_xfer;

endpackage

### rtl/sfbf_front.sv
`timescale 1ns / 1ps
module sfbf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_data,
    output sfbf_pkg::t_cmd_xfer   o_xfer
);
    import sfbf_pkg::*;

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [2:0]        r_slot, n_slot;
    t_sept             r_hb, n_hb;
    t_sept [6:0]       r_grp;
    t_sept             r_cks, n_cks;
    logic [15:0]       r_cnt, n_cnt;
    logic [15:0]       r_sum, n_sum;
    logic              r_fin, n_fin;

    logic        accept, is_data, is_fin, pos0, last;
    t_sept       hb_new, hdr_cks, cks_g;
    t_sept [6:0] grp_new;
    logic [2:0]  grp_len;

    assign accept  = i_push && !i_full;
    assign is_data = ((i_op == OP_IMAGE) || (i_op == OP_PAD)) && !r_fin;
    assign pos0    = (r_pos == '0);
    assign is_fin  = (i_op == OP_FINISH) && !r_fin && pos0;
    assign last    = (r_pos == POS_W'(BLOCK_LEN - 1));

    always_comb begin
        hb_new = (pos0 ? 7'd0 : r_hb) | (t_sept'(i_data[7]) << r_slot);
        for (int k = 0; k < 7; k++) begin
            grp_new[k] = (r_slot == 3'(k)) ? i_data[6:0] : r_grp[k];
        end
        // full group on the seventh byte, short group on the block's last byte
        if (r_slot == 3'd6) begin
            grp_len = 3'd7;
        end else if (last) begin
            grp_len = r_slot + 3'd1;
        end else begin
            grp_len = 3'd0;
        end
        hdr_cks = CMD_BLOCK ^ LEN7 ^ r_addr[6:0] ^ r_addr[13:7]
                ^ r_addr[20:14] ^ r_addr[27:21];
        cks_g = (pos0 ? hdr_cks : r_cks) ^ i_data[6:0];
        if (grp_len != 3'd0) begin
            cks_g = cks_g ^ hb_new;
        end
    end

    always_comb begin
        n_addr = r_addr;
        n_pos  = r_pos;
        n_slot = r_slot;
        n_hb   = r_hb;
        n_cks  = r_cks;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_fin  = r_fin;
        if (accept && is_data) begin
            n_pos  = last ? '0 : r_pos + POS_W'(1);
            n_slot = (last || r_slot == 3'd6) ? 3'd0 : r_slot + 3'd1;
            n_hb   = (grp_len != 3'd0) ? 7'd0 : hb_new;
            n_cks  = last ? 7'd0 : cks_g;
            if (last) begin
                n_addr = r_addr + ADDR_W'(BLOCK_LEN);
            end
            if (i_op == OP_IMAGE) begin
                n_cnt = r_cnt + 16'd1;
                n_sum = r_sum + {8'd0, i_data};
            end
        end else if (accept && is_fin) begin
            n_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pos  <= '0;
            r_slot <= '0;
            r_hb   <= '0;
            r_cks  <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_fin  <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_pos  <= n_pos;
            r_slot <= n_slot;
            r_hb   <= n_hb;
            r_cks  <= n_cks;
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_fin  <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_data) begin
            r_grp <= grp_new;
        end
    end

    always_comb begin
        o_xfer.valid       = accept && ((is_data && (pos0 || grp_len != 3'd0 || last))
                             || is_fin);
        o_xfer.cmd.hdr     = pos0 && !is_fin;
        o_xfer.cmd.addr    = r_addr;
        o_xfer.cmd.grp_len = is_fin ? 3'd0 : grp_len;
        o_xfer.cmd.hb      = hb_new;
        o_xfer.cmd.grp     = grp_new;
        o_xfer.cmd.close   = last && !is_fin;
        o_xfer.cmd.cks     = cks_g;
        o_xfer.cmd.fin     = is_fin;
        o_xfer.cmd.cnt     = r_cnt;
        o_xfer.cmd.sum     = r_sum;
    end

endmodule

### rtl/sfbf_cmdq.sv
`timescale 1ns / 1ps
module sfbf_cmdq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfbf_pkg::t_cmd_xfer i_xfer,
    input  logic                i_deq,
    output logic                o_full,
    output sfbf_pkg::t_cmd_xfer o_head
);
    import sfbf_pkg::*;

    t_cmd            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp, n_wp;
    logic [QA_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            wr, rd;

    assign wr     = i_xfer.valid;
    assign rd     = i_deq && (r_cnt != '0);
    assign o_full = (r_cnt == QC_W'(QDEPTH));

    always_comb begin
        n_wp  = wr ? r_wp + QA_W'(1) : r_wp;
        n_rp  = rd ? r_rp + QA_W'(1) : r_rp;
        n_cnt = r_cnt + QC_W'(wr) - QC_W'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_xfer.cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

endmodule

### rtl/sfbf_back.sv
`timescale 1ns / 1ps
module sfbf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfbf_pkg::t_cmd_xfer i_head,
    output logic                o_deq,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_byte,
    output logic                o_eom,
    output logic                o_last
);
    import sfbf_pkg::*;

    localparam logic [1:0] PH_HDR   = 2'd0;
    localparam logic [1:0] PH_GRP   = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;
    localparam logic [1:0] PH_FIN   = 2'd3;

    t_sept            r_dev;
    logic             r_started;
    logic [1:0]       r_phase;
    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    logic [7:0]       r_byte;
    logic             r_eom;
    logic             r_last;

    t_cmd             cmd;
    logic [1:0]       first_ph, ph, nxt;
    logic [IDX_W-1:0] idx;
    logic [2:0]       gi;
    logic             step, ph_end, done;
    logic [7:0]       byte_v;
    logic             eom_v;

    assign cmd         = i_head.cmd;
    assign o_cfg_ready = 1'b1;
    assign step        = i_head.valid && (!r_ov || i_pop);

    always_comb begin
        if (cmd.fin) begin
            first_ph = PH_FIN;
        end else if (cmd.hdr) begin
            first_ph = PH_HDR;
        end else if (cmd.grp_len != 3'd0) begin
            first_ph = PH_GRP;
        end else begin
            first_ph = PH_CLOSE;
        end
        ph  = r_started ? r_phase : first_ph;
        idx = r_started ? r_idx : '0;
        gi  = 3'(idx - IDX_W'(1));
    end

    // byte generator for the current phase/index
    always_comb begin
        byte_v = 8'h00;
        eom_v  = 1'b0;
        ph_end = 1'b0;
        nxt    = PH_CLOSE;
        done   = 1'b0;
        case (ph)
            PH_HDR: begin
                case (idx)
                    4'd0:    byte_v = SYX_START;
                    4'd1:    byte_v = MFR_ID0;
                    4'd2:    byte_v = MFR_ID1;
                    4'd3:    byte_v = {1'b0, r_dev};
                    4'd4:    byte_v = {1'b0, CMD_BLOCK};
                    4'd5:    byte_v = {1'b0, LEN7};
                    4'd6:    byte_v = {1'b0, cmd.addr[6:0]};
                    4'd7:    byte_v = {1'b0, cmd.addr[13:7]};
                    4'd8:    byte_v = {1'b0, cmd.addr[20:14]};
                    default: byte_v = {1'b0, cmd.addr[27:21]};
                endcase
                ph_end = (idx == 4'd9);
                if (cmd.grp_len != 3'd0) begin
                    nxt = PH_GRP;
                end else begin
                    nxt  = PH_CLOSE;
                    done = ph_end && !cmd.close;
                end
            end
            PH_GRP: begin
                byte_v = (idx == '0) ? {1'b0, cmd.hb} : {1'b0, cmd.grp[gi]};
                ph_end = (idx == {1'b0, cmd.grp_len});
                nxt    = PH_CLOSE;
                done   = ph_end && !cmd.close;
            end
            PH_CLOSE: begin
                byte_v = (idx == '0) ? {1'b0, cmd.cks} : SYX_END;
                eom_v  = (idx != '0);
                ph_end = (idx != '0);
                done   = ph_end;
            end
            PH_FIN: begin
                case (idx)
                    4'd0:    byte_v = SYX_START;
                    4'd1:    byte_v = MFR_ID0;
                    4'd2:    byte_v = MFR_ID1;
                    4'd3:    byte_v = {1'b0, r_dev};
                    4'd4:    byte_v = {1'b0, CMD_SUM};
                    4'd5:    byte_v = {1'b0, cmd.cnt[6:0]};
                    4'd6:    byte_v = {1'b0, cmd.cnt[13:7]};
                    4'd7:    byte_v = {6'd0, cmd.cnt[15:14]};
                    4'd8:    byte_v = {1'b0, cmd.sum[6:0]};
                    4'd9:    byte_v = {1'b0, cmd.sum[13:7]};
                    default: byte_v = SYX_END;
                endcase
                eom_v  = (idx == 4'd10);
                ph_end = eom_v;
                done   = ph_end;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign o_deq = step && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev     <= DEV_ID_RST;
            r_started <= 1'b0;
            r_phase   <= PH_HDR;
            r_idx     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dev <= i_cfg_data;
            end
            if (step) begin
                r_ov <= 1'b1;
                if (done) begin
                    r_started <= 1'b0;
                end else begin
                    r_started <= 1'b1;
                    r_phase   <= ph_end ? nxt : ph;
                    r_idx     <= ph_end ? '0 : idx + IDX_W'(1);
                end
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= byte_v;
            r_eom  <= eom_v;
            r_last <= done;
        end
    end

    assign o_empty = !r_ov;
    assign o_byte  = r_byte;
    assign o_eom   = r_eom;
    assign o_last  = r_last;

endmodule

### rtl/sysex_firmware_block_framer.sv
`timescale 1ns / 1ps
// SysEx firmware block framer. Image/padding bytes and a finish request go in
// through push/full; framed SysEx bytes come out through empty/pop, one byte
// per clock at most. The front end takes one input item per clock while its
// 4-entry command queue has room and never stalls on its own; throughput is
// set by the byte sequencer, which emits 86 bytes per 64-byte block (header,
// packed groups, checksum, F7) and 11 bytes for the finish message. The first
// byte of an item passes through the command queue and the output byte
// register before it shows up. Items that cause no output (finish inside an
// open block, anything after finish, op 3) are taken and dropped. device_id
// may be written at any time the block is idle.
`include "sysex_firmware_block_framer_macros.svh"
module sysex_firmware_block_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_message,
    output logic       o_last_of_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);
    import sfbf_pkg::*;

    t_cmd_xfer front_xfer;
    t_cmd_xfer q_head;
    logic      q_deq;

    sfbf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_full  (full),
        .i_op    (i_op),
        .i_data  (i_data),
        .o_xfer  (front_xfer)
    );

    sfbf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xfer  (front_xfer),
        .i_deq   (q_deq),
        .o_full  (full),
        .o_head  (q_head)
    );

    sfbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_deq       (q_deq),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_byte      (o_out_byte),
        .o_eom       (o_end_of_message),
        .o_last      (o_last_of_item)
    );

    `SFBF_ASSERT_NOW(a_eom_is_last, !empty && o_end_of_message, o_last_of_item, "F7 not last of item")
    `SFBF_ASSERT_NOW(a_eom_byte, !empty && o_end_of_message, o_out_byte == SYX_END, "eom without F7")
    `SFBF_ASSERT_NOW(a_status_only, !empty && o_out_byte[7], (o_out_byte == SYX_START) || (o_out_byte == SYX_END), "data byte with bit 7 set")
    `SFBF_ASSERT_NEXT(a_item_continues, !empty && !o_last_of_item, !empty, "gap inside an item's bytes")

endmodule

### tb/sysex_firmware_block_framer_test.sv
`timescale 1ns / 1ps
module sysex_firmware_block_framer_test;
    import sfbf_pkg::*;

    localparam logic [1:0] OP_RSVD   = 2'd3;
    localparam int         DIR_N     = 21;
    localparam int         PHASE_N   = 28;
    localparam int         DRAIN_CYC = 16;
    localparam int         HOLD_CYC  = 300;

    typedef struct packed {
        logic [7:0] val;
        logic       eom;
        logic       last;
    } sysex_byte_t;

    // one directed or random input item; typed rows carry their own expected bytes
    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data;
        logic             typed;
        logic [3:0]       n;
        logic [0:10][7:0] xb;
    } stim_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_op;
    logic [7:0] i_data;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_end_of_message;
    logic       o_last_of_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;

    sysex_firmware_block_framer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_data           (i_data),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_end_of_message (o_end_of_message),
        .o_last_of_item   (o_last_of_item),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    sysex_byte_t sysex_exp[$];
    sysex_byte_t frame_bytes[$];
    stim_row_t   dir_tab[DIR_N];

    int mismatches = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_pending = 1'b0;

    // framer state mirror
    logic [6:0]  dev_id;
    logic [27:0] blk_addr;
    logic [6:0]  blk_pos;
    t_sept       hb_acc;
    t_sept       grp_buf[7];
    t_sept       blk_cks;
    logic [15:0] img_cnt;
    logic [15:0] img_sum;
    logic        img_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function void emit_b(logic [7:0] b, logic eom);
        frame_bytes.push_back('{val: b, eom: eom, last: 1'b0});
    endfunction

    function void emit_head(t_sept cmd);
        emit_b(SYX_START, 1'b0);
        emit_b(MFR_ID0, 1'b0);
        emit_b(MFR_ID1, 1'b0);
        emit_b({1'b0, dev_id}, 1'b0);
        emit_b({1'b0, cmd}, 1'b0);
    endfunction

    function void emit_grp(int len);
        blk_cks ^= hb_acc;
        emit_b({1'b0, hb_acc}, 1'b0);
        for (int k = 0; k < len; k++)
            emit_b({1'b0, grp_buf[k]}, 1'b0);
        hb_acc = '0;
    endfunction

    // SysEx bytes caused by one accepted item, left in frame_bytes
    function void frame_item(logic [1:0] op, logic [7:0] data);
        int    slot;
        t_sept g;
        frame_bytes.delete();
        if (img_done || op == OP_RSVD)
            return;
        if (op == OP_FINISH) begin
            if (blk_pos != 0)
                return;
            emit_head(CMD_SUM);
            emit_b({1'b0, img_cnt[6:0]}, 1'b0);
            emit_b({1'b0, img_cnt[13:7]}, 1'b0);
            emit_b({6'b0, img_cnt[15:14]}, 1'b0);
            emit_b({1'b0, img_sum[6:0]}, 1'b0);
            emit_b({1'b0, img_sum[13:7]}, 1'b0);
            emit_b(SYX_END, 1'b1);
            img_done = 1'b1;
        end else begin
            slot = int'(blk_pos % 7);
            if (blk_pos == 0) begin
                emit_head(CMD_BLOCK);
                emit_b({1'b0, LEN7}, 1'b0);
                blk_cks = CMD_BLOCK ^ LEN7;
                for (int k = 0; k < 4; k++) begin
                    g = blk_addr[7*k +: 7];
                    blk_cks ^= g;
                    emit_b({1'b0, g}, 1'b0);
                end
                hb_acc = '0;
            end
            if (op == OP_IMAGE) begin
                img_cnt = img_cnt + 16'd1;
                img_sum = img_sum + {8'd0, data};
            end
            hb_acc[slot]  = data[7];
            grp_buf[slot] = data[6:0];
            blk_cks ^= data[6:0];
            if (slot == 6)
                emit_grp(7);
            blk_pos = blk_pos + 7'd1;
            if (blk_pos >= BLOCK_LEN) begin
                if (blk_pos % 7 != 0)
                    emit_grp(int'(blk_pos % 7));
                emit_b({1'b0, blk_cks}, 1'b0);
                emit_b(SYX_END, 1'b1);
                blk_pos  = '0;
                blk_cks  = '0;
                blk_addr = blk_addr + 28'(BLOCK_LEN);
            end
        end
        if (frame_bytes.size() > 0)
            frame_bytes[frame_bytes.size() - 1].last = 1'b1;
    endfunction

    function stim_row_t plain(logic [1:0] op, logic [7:0] data);
        return '{op: op, data: data, typed: 1'b0, n: 4'd0, xb: '0};
    endfunction

    function stim_row_t quiet(logic [1:0] op, logic [7:0] data);
        return '{op: op, data: data, typed: 1'b1, n: 4'd0, xb: '0};
    endfunction

    function stim_row_t rand_row();
        int        r;
        stim_row_t s;
        r = $urandom_range(99);
        s = plain(OP_IMAGE, 8'($urandom_range(255)));
        if (r < 20)
            s.op = OP_PAD;
        else if (r < 25)
            s.op = OP_RSVD;
        else if (r < 30 && blk_pos != 0)
            s.op = OP_FINISH;
        if ($urandom_range(7) == 0)
            s.data = $urandom_range(1) ? 8'hFF : 8'h00;
        return s;
    endfunction

    // holds the item until the push transaction completes, then queues its bytes
    task automatic offer(input stim_row_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_op   <= r.op;
        i_data <= r.data;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        frame_item(r.op, r.data);
        if (r.typed) begin
            for (int k = 0; k < r.n; k++)
                sysex_exp.push_back('{val: r.xb[k], eom: 1'b0, last: (k == r.n - 1)});
        end else begin
            foreach (frame_bytes[k])
                sysex_exp.push_back(frame_bytes[k]);
        end
    endtask

    task automatic settle();
        while (sysex_exp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_dev(input logic [6:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dev_id = v;
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [6:0] dev,
                             input bit squeeze);
        settle();
        write_dev(dev);
        idle_pct  = idle;
        stall_pct = stall;
        if (squeeze)
            hold_pending = 1'b1;
        repeat (PHASE_N) offer(rand_row());
        // keep offering until the receiver lets go, so the block backs up
        while (hold_pending) offer(rand_row());
        push <= 1'b0;
    endtask

    // receiver side; a pending hold keeps pop low for a long stretch
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                pop <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : mon
        sysex_byte_t want;
        if (i_rst_n && pop && !empty) begin
            if (sysex_exp.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %02h", o_out_byte));
            end else begin
                want = sysex_exp.pop_front();
                if (o_out_byte !== want.val)
                    note_mismatch($sformatf("out_byte %02h, want %02h", o_out_byte, want.val));
                if (o_end_of_message !== want.eom)
                    note_mismatch($sformatf("end_of_message %b, want %b (byte %02h)",
                                            o_end_of_message, want.eom, want.val));
                if (o_last_of_item !== want.last)
                    note_mismatch($sformatf("last_of_item %b, want %b (byte %02h)",
                                            o_last_of_item, want.last, want.val));
            end
        end
    end

    initial begin
        stim_row_t tail_row;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_op        <= OP_IMAGE;
        i_data      <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;

        dev_id   = DEV_ID_RST;
        blk_addr = '0;
        blk_pos  = '0;
        hb_acc   = '0;
        blk_cks  = '0;
        img_cnt  = '0;
        img_sum  = '0;
        img_done = 1'b0;

        dir_tab = '{
            '{op: OP_IMAGE, data: 8'hFF, typed: 1'b1, n: 4'd10,
              xb: {8'hF0, 8'h00, 8'h13, 8'h38, 8'h01, 8'h40,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            plain(OP_IMAGE, 8'h00), plain(OP_IMAGE, 8'h80), plain(OP_IMAGE, 8'h7F),
            plain(OP_IMAGE, 8'h01), plain(OP_PAD, 8'hFE), plain(OP_IMAGE, 8'hAA),
            quiet(OP_RSVD, 8'h55),
            quiet(OP_FINISH, 8'h00),          // block open, dropped
            plain(OP_PAD, 8'h00), plain(OP_PAD, 8'hFF), plain(OP_IMAGE, 8'h80),
            quiet(OP_FINISH, 8'hFF),
            quiet(OP_RSVD, 8'hFF),
            plain(OP_IMAGE, 8'h7F), plain(OP_IMAGE, 8'hFF), plain(OP_PAD, 8'h80),
            plain(OP_IMAGE, 8'h55), plain(OP_IMAGE, 8'hFF), plain(OP_IMAGE, 8'h00),
            plain(OP_PAD, 8'h7F)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            offer(dir_tab[k]);
        push <= 1'b0;

        run_phase(0, 0, 7'h7F, 1'b0);
        run_phase(74, 0, 7'h00, 1'b0);
        run_phase(0, 74, 7'($urandom_range(127)), 1'b1);
        run_phase(36, 36, 7'h7F, 1'b0);

        // close the open block, then finish; everything after finish is dropped
        settle();
        write_dev(7'($urandom_range(127)));
        idle_pct  = 20;
        stall_pct = 20;
        while (blk_pos != 0) begin
            tail_row = plain($urandom_range(3) == 0 ? OP_PAD : OP_IMAGE,
                             8'($urandom_range(255)));
            offer(tail_row);
        end
        offer(plain(OP_FINISH, 8'($urandom_range(255))));
        offer(plain(OP_IMAGE, 8'($urandom_range(255))));
        offer(plain(OP_FINISH, 8'h00));
        offer(plain(OP_PAD, 8'($urandom_range(255))));
        push <= 1'b0;

        settle();
        if (sysex_exp.size() != 0)
            note_mismatch($sformatf("%0d bytes never arrived", sysex_exp.size()));
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
